@@ hw/rtl/ple_pkg.sv @@
// shared types and constants for the positional list engine
// no dependencies; used by ple_cell and positional_list_engine_top

package ple_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 5;

  localparam logic [POS_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_PEEK   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic [POS_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

@@ hw/rtl/ple_cell.sv @@
// one storage cell of the list row: holds, loads, or takes a neighbor's value
// depends on ple_pkg

module ple_cell #(
  parameter int INDEX = 0
) (
  input  logic                              clk,
  input  ple_pkg::cell_cmd_t                cmd,
  input  logic signed [ple_pkg::DATA_W-1:0] left_value,
  input  logic signed [ple_pkg::DATA_W-1:0] right_value,
  output logic signed [ple_pkg::DATA_W-1:0] value_q,
  output logic signed [ple_pkg::DATA_W-1:0] read_out
);

  logic signed [ple_pkg::DATA_W-1:0] value_next;
  logic                              hit;
  logic                              above;

  always_comb begin
    hit   = (int'(cmd.idx) == INDEX);
    above = (int'(cmd.idx) < INDEX);
    value_next = value_q;
    if (cmd.ins) begin
      if (hit) begin
        value_next = cmd.value;
      end else if (above) begin
        value_next = left_value;
      end
    end else if (cmd.rem) begin
      if (hit || above) begin
        value_next = right_value;
      end
    end
    read_out = hit ? value_q : '0;
  end

  always_ff @(posedge clk) begin
    value_q <= value_next;
  end

endmodule

@@ hw/rtl/positional_list_engine_top.sv @@
// top level of the positional list engine: control, cell row, result register
// depends on ple_pkg and ple_cell
//
// usage:
//   requests arrive on in_valid/in_ready with mode, position and value.
//   insert puts value after position (0 puts it first), remove takes out
//   and returns the value at position, peek returns it unchanged.
//   one result per request on out_valid/out_ready: read_value, status,
//   occupancy and not_empty.
//   every cell picks hold, load or neighbor shift in parallel, so a request is
//   accepted every cycle while in_ready is high, and its result is registered
//   and shown in the next cycle. while a result waits, the next request is
//   still taken if out_ready is high in the same cycle; a stalled receiver
//   holds in_ready low. capacity_limit is to be written through
//   cfg_wr_en/cfg_wr_data only while idle; the block does not enforce this.
//   reset empties the list, drops any waiting result, holds in_ready low and
//   sets the capacity limit to 16. entries never written read as anything.

module positional_list_engine_top #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [ple_pkg::POS_W-1:0]         cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        mode,
  input  logic [ple_pkg::POS_W-1:0]         position,
  input  logic signed [ple_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ple_pkg::DATA_W-1:0] read_value,
  output logic [1:0]                        status,
  output logic [ple_pkg::POS_W-1:0]         occupancy,
  output logic                              not_empty
);

  localparam logic [ple_pkg::POS_W-1:0] DEPTH_CAP =
    (DEPTH > 31) ? 5'd31 : ple_pkg::POS_W'(DEPTH);

  logic [ple_pkg::POS_W-1:0]         cap_limit;
  logic [ple_pkg::POS_W-1:0]         count;
  logic [ple_pkg::POS_W-1:0]         count_next;
  logic [ple_pkg::POS_W-1:0]         limit;
  logic                              accept;
  ple_pkg::status_t                  st;
  ple_pkg::cell_cmd_t                cmd;
  logic signed [ple_pkg::DATA_W-1:0] rd_data;
  logic signed [ple_pkg::DATA_W-1:0] cell_q    [DEPTH];
  logic signed [ple_pkg::DATA_W-1:0] cell_read [DEPTH];

  assign in_ready = !rst && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign limit    = (cap_limit < DEPTH_CAP) ? cap_limit : DEPTH_CAP;

  // decode request against current occupancy
  always_comb begin
    st         = ple_pkg::STATUS_OK;
    count_next = count;
    cmd.ins    = 1'b0;
    cmd.rem    = 1'b0;
    cmd.idx    = position;
    cmd.value  = value;
    case (mode)
      ple_pkg::MODE_INSERT: begin
        if (count >= limit) begin
          st = ple_pkg::STATUS_FULL;
        end else if (position > count) begin
          st = ple_pkg::STATUS_RANGE;
        end else begin
          cmd.ins    = accept;
          count_next = count + 5'd1;
        end
      end
      ple_pkg::MODE_REMOVE, ple_pkg::MODE_PEEK: begin
        cmd.idx = position - 5'd1;
        if (position == '0 || position > count) begin
          st = ple_pkg::STATUS_RANGE;
        end else if (mode == ple_pkg::MODE_REMOVE) begin
          cmd.rem    = accept;
          count_next = count - 5'd1;
        end
      end
      default: begin
        st = ple_pkg::STATUS_RANGE;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ple_pkg::DATA_W-1:0] left_v;
    logic signed [ple_pkg::DATA_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_left
      assign left_v = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_right
      assign right_v = cell_q[i+1];
    end
    ple_cell #(
      .INDEX(i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .left_value (left_v),
      .right_value(right_v),
      .value_q    (cell_q[i]),
      .read_out   (cell_read[i])
    );
  end

  // at most one cell drives a nonzero read
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_data = rd_data | cell_read[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_limit <= ple_pkg::CAP_RESET;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_limit <= cfg_wr_data;
      end
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value <= (st == ple_pkg::STATUS_OK && mode != ple_pkg::MODE_INSERT) ?
                    rd_data : '0;
      status     <= st;
      occupancy  <= count_next;
      not_empty  <= (count_next != '0);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CAP)
    else $error("occupancy exceeds cell row");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == ple_pkg::MODE_INSERT && st == ple_pkg::STATUS_OK)
    |=> count == 5'($past(count) + 5'd1))
    else $error("accepted insert did not grow the list");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ple_pkg::STATUS_OK) |-> read_value == '0)
    else $error("error result carries data");

  a_occ_match: assert property (@(posedge clk) disable iff (rst)
    $past(accept) |-> occupancy == count)
    else $error("result occupancy differs from list state");

endmodule

@@ tb/sv/tb_positional_list_engine_top.sv @@
// self-checking testbench for positional_list_engine_top: directed and random
// insert/remove/peek traffic checked against an in-bench list predictor
// depends on ple_pkg and the positional_list_engine_top rtl

module tb_positional_list_engine_top;

  localparam int LIST_DEPTH = 16;
  localparam int STUCK_LIMIT = 3000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic signed [ple_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [ple_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [ple_pkg::DATA_W-1:0] read_value;
    ple_pkg::status_t                  status;
    logic [ple_pkg::POS_W-1:0]         occupancy;
    logic                              not_empty;
  } list_result_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_wr_en = 1'b0;
  logic [ple_pkg::POS_W-1:0]         cfg_wr_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [1:0]                        mode = ple_pkg::MODE_INSERT;
  logic [ple_pkg::POS_W-1:0]         position = '0;
  logic signed [ple_pkg::DATA_W-1:0] value = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [ple_pkg::DATA_W-1:0] read_value;
  logic [1:0]                        status;
  logic [ple_pkg::POS_W-1:0]         occupancy;
  logic                              not_empty;

  logic signed [ple_pkg::DATA_W-1:0] held_values [LIST_DEPTH];
  int                                held_count = 0;
  int                                capacity_q = int'(ple_pkg::CAP_RESET);
  list_result_t                      pending_results [$];
  list_result_t                      oldest_result;
  int                                errors = 0;
  int                                stuck_cycles = 0;
  bit                                idle_en = 1'b1;

  positional_list_engine_top DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .position(position),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_value(read_value),
    .status(status),
    .occupancy(occupancy),
    .not_empty(not_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic list_result_t apply_request(logic [1:0] op,
                                                 logic [ple_pkg::POS_W-1:0] pos,
                                                 logic signed [ple_pkg::DATA_W-1:0] val);
    list_result_t r;
    int lim;
    r = '0;
    r.status = ple_pkg::STATUS_OK;
    lim = (capacity_q < LIST_DEPTH) ? capacity_q : LIST_DEPTH;
    case (op)
      ple_pkg::MODE_INSERT: begin
        if (held_count >= lim) begin
          r.status = ple_pkg::STATUS_FULL;
        end else if (pos > held_count) begin
          r.status = ple_pkg::STATUS_RANGE;
        end else begin
          for (int i = held_count; i > pos; i--) held_values[i] = held_values[i-1];
          held_values[pos] = val;
          held_count++;
        end
      end
      ple_pkg::MODE_REMOVE, ple_pkg::MODE_PEEK: begin
        if (pos == 0 || pos > held_count) begin
          r.status = ple_pkg::STATUS_RANGE;
        end else begin
          r.read_value = held_values[pos-1];
          if (op == ple_pkg::MODE_REMOVE) begin
            for (int i = pos - 1; i + 1 < held_count; i++) held_values[i] = held_values[i+1];
            held_count--;
          end
        end
      end
      default: r.status = ple_pkg::STATUS_RANGE;
    endcase
    r.occupancy = ple_pkg::POS_W'(held_count);
    r.not_empty = (held_count != 0);
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [ple_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return 0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // called at a rising edge; returns at the edge that accepts the request
  task automatic send_request(logic [1:0] op, logic [ple_pkg::POS_W-1:0] pos,
                              logic signed [ple_pkg::DATA_W-1:0] val);
    in_valid <= 1'b1;
    mode <= op;
    position <= pos;
    value <= val;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    pending_results.push_back(apply_request(op, pos, val));
    @(posedge clk);
  endtask

  task automatic tx_pause();
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_capacity(logic [ple_pkg::POS_W-1:0] cap);
    wait_for_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    capacity_q = int'(cap);
  endtask

  task automatic check_field(string name, logic [ple_pkg::DATA_W-1:0] want,
                             logic [ple_pkg::DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending: expected none actual %0h/%0d/%0d/%0d",
                 $time, read_value, status, occupancy, not_empty);
        errors++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("read_value", oldest_result.read_value, read_value);
        check_field("status", oldest_result.status, status);
        check_field("occupancy", oldest_result.occupancy, occupancy);
        check_field("not_empty", oldest_result.not_empty, not_empty);
      end
    end
  end

  // receiver back-pressure
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = gap_len();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("positional_list_engine_top regression: fail");
        $finish;
      end
    end
  end

  task automatic test_empty_list();
    send_request(ple_pkg::MODE_PEEK, 1, 0);
    send_request(ple_pkg::MODE_REMOVE, 0, 0);
    send_request(MODE_UNUSED, 0, VAL_MAX);
    send_request(ple_pkg::MODE_INSERT, 1, 5);
  endtask

  task automatic test_insert_order();
    send_request(ple_pkg::MODE_INSERT, 0, VAL_MAX);
    tx_pause();
    send_request(ple_pkg::MODE_INSERT, 1, VAL_MIN);
    send_request(ple_pkg::MODE_INSERT, 1, 0);
    send_request(ple_pkg::MODE_INSERT, 0, -1);
    tx_pause();
    send_request(ple_pkg::MODE_INSERT, 5, 7);
    send_request(ple_pkg::MODE_PEEK, 4, 0);
    send_request(ple_pkg::MODE_PEEK, 31, 0);
  endtask

  task automatic test_remove_shift();
    send_request(ple_pkg::MODE_REMOVE, 2, 0);
    send_request(ple_pkg::MODE_REMOVE, 3, 0);
    tx_pause();
    send_request(ple_pkg::MODE_REMOVE, 0, 0);
    send_request(ple_pkg::MODE_REMOVE, 1, 0);
    send_request(ple_pkg::MODE_REMOVE, 1, 0);
  endtask

  task automatic test_capacity_limit();
    set_capacity(3);
    repeat (3) send_request(ple_pkg::MODE_INSERT, 0, pick_value());
    send_request(ple_pkg::MODE_INSERT, 31, 1);
    // lowered below occupancy
    set_capacity(1);
    send_request(ple_pkg::MODE_PEEK, 3, 0);
    send_request(ple_pkg::MODE_INSERT, 0, 2);
    send_request(ple_pkg::MODE_REMOVE, 1, 0);
    send_request(ple_pkg::MODE_REMOVE, 1, 0);
    send_request(ple_pkg::MODE_INSERT, 1, 3);
    set_capacity(0);
    send_request(ple_pkg::MODE_INSERT, 0, 4);
    send_request(ple_pkg::MODE_REMOVE, 1, 0);
  endtask

  task automatic random_phase(int count, logic [ple_pkg::POS_W-1:0] cap, bit quiet);
    int fill_pct;
    int r;
    logic [1:0] op;
    logic [ple_pkg::POS_W-1:0] pos;
    fill_pct = 70;
    set_capacity(cap);
    idle_en = !quiet;
    for (int k = 0; k < count; k++) begin
      if (k % 80 == 0) fill_pct = ((k / 80) % 2) ? 25 : 70;
      if (k == count / 2) wait_for_results();
      r = $urandom_range(0, 99);
      if (r < 3) op = MODE_UNUSED;
      else if (r < 3 + fill_pct) op = ple_pkg::MODE_INSERT;
      else if (r % 3 == 0) op = ple_pkg::MODE_PEEK;
      else op = ple_pkg::MODE_REMOVE;
      if ($urandom_range(0, 9) == 0) pos = ple_pkg::POS_W'($urandom_range(0, 31));
      else if (op == ple_pkg::MODE_INSERT) pos = ple_pkg::POS_W'($urandom_range(0, held_count));
      else if (held_count == 0) pos = 1;
      else pos = ple_pkg::POS_W'($urandom_range(1, held_count));
      send_request(op, pos, pick_value());
      tx_pause();
    end
    idle_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    random_phase(500, 16, 1'b0);
    random_phase(350, 31, 1'b0);
    random_phase(120, 1, 1'b0);
    random_phase(40, 0, 1'b0);
    repeat (3) random_phase(150, ple_pkg::POS_W'($urandom_range(2, 15)), 1'b0);
    random_phase(300, 16, 1'b1);
    random_phase(120, ple_pkg::POS_W'($urandom_range(1, 31)), 1'b0);
  endtask

  initial begin
    for (int i = 0; i < LIST_DEPTH; i++) held_values[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_insert_order();
    test_remove_shift();
    test_capacity_limit();
    test_random_traffic();
    wait_for_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("positional_list_engine_top regression: pass");
    end else begin
      $display("positional_list_engine_top regression: fail");
    end
    $finish;
  end

endmodule

@@ positional_list_engine_top.f @@
hw/rtl/ple_pkg.sv
hw/rtl/ple_cell.sv
hw/rtl/positional_list_engine_top.sv
tb/sv/tb_positional_list_engine_top.sv
